[src/wmt_pkg.sv]
// ----------------------------------------------------------------------------
// wmt_pkg
// Shared types and constants of the windowed mean / min / max tracker.
// ----------------------------------------------------------------------------
package wmt_pkg;

  localparam int unsigned CH_BITS      = 2;
  localparam int unsigned CFG_REGS     = 8;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_BITS     = 16;
  localparam int unsigned MID_DEPTH    = 2;
  localparam int unsigned OUT_DEPTH    = 8;

  localparam logic signed [CFG_BITS-1:0] BOUND_LO_RESET = 16'sh8000;
  localparam logic signed [CFG_BITS-1:0] BOUND_HI_RESET = 16'sh7FFF;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_CLEAR,
    KIND_SKIP
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [CH_BITS-1:0] channel;
  } ctrl_t;

endpackage

[src/wmt_fifo.sv]
// ----------------------------------------------------------------------------
// wmt_fifo
// Small register queue, power-of-two depth, first-word fall-through.
// ----------------------------------------------------------------------------
module wmt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [WIDTH-1:0]         data_i,
  input  logic                     pop_i,
  output logic [WIDTH-1:0]         data_o,
  output logic                     full_o,
  output logic                     empty_o,
  output logic [$clog2(DEPTH):0]   count_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [AW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[src/wmt_front.sv]
// ----------------------------------------------------------------------------
// wmt_front
// Input stage: takes items, classifies them and feeds the command queue.
// ----------------------------------------------------------------------------
module wmt_front
  import wmt_pkg::*;
#(
  parameter int unsigned CHANNELS    = 4,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic                          operation_i,
  input  logic [CH_BITS-1:0]            channel_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          q_push_o,
  output ctrl_t                         q_ctrl_o,
  output logic signed [SAMPLE_BITS-1:0] q_sample_o,
  input  logic                          q_full_i
);

  logic                          fr_vld_q, fr_vld_d;
  ctrl_t                         fr_ctrl_q, fr_ctrl_d;
  logic signed [SAMPLE_BITS-1:0] fr_sample_q;
  logic                          accept;

  assign full_o   = fr_vld_q & q_full_i;
  assign accept   = push_i & ~full_o;
  assign q_push_o = fr_vld_q & ~q_full_i;
  assign fr_vld_d = accept | (fr_vld_q & q_full_i);

  always_comb begin
    fr_ctrl_d.channel = channel_i;
    if (32'(channel_i) >= CHANNELS) begin
      fr_ctrl_d.kind = KIND_SKIP;
    end else if (operation_i == OP_CLEAR) begin
      fr_ctrl_d.kind = KIND_CLEAR;
    end else begin
      fr_ctrl_d.kind = KIND_SAMPLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_vld_q <= 1'b0;
    end else begin
      fr_vld_q <= fr_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fr_ctrl_q   <= fr_ctrl_d;
      fr_sample_q <= sample_i;
    end
  end

  assign q_ctrl_o   = fr_ctrl_q;
  assign q_sample_o = fr_sample_q;

endmodule

[src/wmt_back.sv]
// ----------------------------------------------------------------------------
// wmt_back
// Channel state update and mean pipeline (reciprocal multiply divide).
// ----------------------------------------------------------------------------
module wmt_back
  import wmt_pkg::*;
#(
  parameter int unsigned CHANNELS    = 4,
  parameter int unsigned WINDOW      = 5,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic signed [CFG_BITS-1:0]    cfg_data_i,
  input  logic                          q_empty_i,
  input  ctrl_t                         q_ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] q_sample_i,
  output logic                          q_pop_o,
  input  logic [$clog2(OUT_DEPTH):0]    out_count_i,
  output logic                          res_push_o,
  output logic [CH_BITS-1:0]            res_channel_o,
  output logic signed [SAMPLE_BITS-1:0] res_mean_o,
  output logic signed [SAMPLE_BITS-1:0] res_min_o,
  output logic signed [SAMPLE_BITS-1:0] res_max_o
);

  localparam int unsigned CIW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned LW   = $clog2(WINDOW);
  localparam int unsigned SUMW = SAMPLE_BITS + LW;
  localparam int unsigned TW   = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;
  localparam int unsigned KSH  = SUMW + LW;
  localparam int unsigned MW   = SUMW + 1;
  localparam int unsigned HB   = SUMW / 2;
  localparam int unsigned HIW  = SUMW - HB;
  localparam int unsigned PRW  = SUMW + MW;
  localparam int unsigned OCW  = $clog2(OUT_DEPTH) + 2;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << KSH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MW-1:0] RECIP    = RECIP64[MW-1:0];
  localparam logic [PW-1:0] LAST_POS = PW'(WINDOW - 1);

  // configuration
  logic signed [CFG_BITS-1:0] cfg_q [CFG_REGS];

  // channel state
  logic signed [SAMPLE_BITS-1:0] ring_q [CHANNELS][WINDOW];
  logic signed [SUMW-1:0]        sum_q  [CHANNELS];
  logic [PW-1:0]                 pos_q  [CHANNELS];
  logic signed [TW-1:0]          min_q  [CHANNELS];
  logic signed [TW-1:0]          max_q  [CHANNELS];

  // issue
  logic [OCW-1:0]                used;
  logic                          issue;
  logic [CIW-1:0]                ch_idx;
  logic [PW-1:0]                 pos, pos_nxt;
  logic signed [SAMPLE_BITS-1:0] old_smp;
  logic signed [TW-1:0]          x_ext, lo_ext, hi_ext, min_nxt, max_nxt;
  logic signed [SUMW-1:0]        sum_new;
  logic signed [SUMW-1:0]        a_sum_d;
  logic signed [SAMPLE_BITS-1:0] a_min_d, a_max_d;

  // pipeline
  logic                          a_vld_q, b_vld_q, c_vld_q, d_vld_q;
  logic [CH_BITS-1:0]            a_ch_q, b_ch_q, c_ch_q, d_ch_q;
  logic signed [SAMPLE_BITS-1:0] a_min_q, b_min_q, c_min_q, d_min_q;
  logic signed [SAMPLE_BITS-1:0] a_max_q, b_max_q, c_max_q, d_max_q;
  logic signed [SUMW-1:0]        a_sum_q;
  logic                          b_neg_q, c_neg_q, d_neg_q;
  logic [SUMW-1:0]               b_mag_q;
  logic [HB+MW-1:0]              c_plo_q;
  logic [HIW+MW-1:0]             c_phi_q;
  logic [PRW-1:0]                prod, quo;
  logic [SAMPLE_BITS-1:0]        d_quo_q;

  assign used = OCW'(out_count_i) + OCW'(a_vld_q) + OCW'(b_vld_q)
              + OCW'(c_vld_q) + OCW'(d_vld_q);
  assign issue   = ~q_empty_i & (used < OCW'(OUT_DEPTH));
  assign q_pop_o = issue;

  always_comb begin
    ch_idx  = q_ctrl_i.channel[CIW-1:0];
    pos     = pos_q[ch_idx];
    pos_nxt = (pos == LAST_POS) ? '0 : pos + 1'b1;
    old_smp = ring_q[ch_idx][pos];
    x_ext   = TW'(q_sample_i);
    lo_ext  = TW'(cfg_q[{q_ctrl_i.channel, 1'b0}]);
    hi_ext  = TW'(cfg_q[{q_ctrl_i.channel, 1'b1}]);
    sum_new = sum_q[ch_idx] - SUMW'(old_smp) + SUMW'(q_sample_i);
    min_nxt = min_q[ch_idx];
    max_nxt = max_q[ch_idx];
    a_sum_d = '0;
    case (q_ctrl_i.kind)
      KIND_SAMPLE: begin
        a_sum_d = (WINDOW > 1) ? sum_new : SUMW'(q_sample_i);
        if (x_ext < min_nxt) begin
          min_nxt = x_ext;
        end
        if (x_ext > max_nxt) begin
          max_nxt = x_ext;
        end
      end
      KIND_CLEAR: begin
        min_nxt = hi_ext;
        max_nxt = lo_ext;
      end
      default: begin
        min_nxt = '0;
        max_nxt = '0;
      end
    endcase
    a_min_d = min_nxt[SAMPLE_BITS-1:0];
    a_max_d = max_nxt[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < CFG_REGS; r++) begin
        cfg_q[r] <= (r % 2 == 0) ? BOUND_LO_RESET : BOUND_HI_RESET;
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int w = 0; w < WINDOW; w++) begin
          ring_q[c][w] <= '0;
        end
        sum_q[c] <= '0;
        pos_q[c] <= '0;
        min_q[c] <= TW'(BOUND_HI_RESET);
        max_q[c] <= TW'(BOUND_LO_RESET);
      end
    end else if (issue) begin
      case (q_ctrl_i.kind)
        KIND_SAMPLE: begin
          if (WINDOW > 1) begin
            ring_q[ch_idx][pos] <= q_sample_i;
            sum_q[ch_idx]       <= sum_new;
            pos_q[ch_idx]       <= pos_nxt;
          end
          min_q[ch_idx] <= min_nxt;
          max_q[ch_idx] <= max_nxt;
        end
        KIND_CLEAR: begin
          for (int w = 0; w < WINDOW; w++) begin
            ring_q[ch_idx][w] <= '0;
          end
          sum_q[ch_idx] <= '0;
          pos_q[ch_idx] <= '0;
          min_q[ch_idx] <= min_nxt;
          max_q[ch_idx] <= max_nxt;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      a_vld_q <= issue;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  assign prod = (PRW'(c_phi_q) << HB) + PRW'(c_plo_q);
  assign quo  = prod >> KSH;

  always_ff @(posedge clk_i) begin
    a_ch_q  <= q_ctrl_i.channel;
    a_sum_q <= a_sum_d;
    a_min_q <= a_min_d;
    a_max_q <= a_max_d;

    b_ch_q  <= a_ch_q;
    b_neg_q <= a_sum_q[SUMW-1];
    b_mag_q <= a_sum_q[SUMW-1] ? (~a_sum_q + 1'b1) : a_sum_q;
    b_min_q <= a_min_q;
    b_max_q <= a_max_q;

    c_ch_q  <= b_ch_q;
    c_neg_q <= b_neg_q;
    c_plo_q <= (HB+MW)'(b_mag_q[HB-1:0]) * (HB+MW)'(RECIP);
    c_phi_q <= (HIW+MW)'(b_mag_q[SUMW-1:HB]) * (HIW+MW)'(RECIP);
    c_min_q <= b_min_q;
    c_max_q <= b_max_q;

    d_ch_q  <= c_ch_q;
    d_neg_q <= c_neg_q;
    d_quo_q <= quo[SAMPLE_BITS-1:0];
    d_min_q <= c_min_q;
    d_max_q <= c_max_q;
  end

  assign res_push_o    = d_vld_q;
  assign res_channel_o = d_ch_q;
  assign res_mean_o    = d_neg_q ? (~d_quo_q + 1'b1) : d_quo_q;
  assign res_min_o     = d_min_q;
  assign res_max_o     = d_max_q;

endmodule

[src/windowed_mean_min_max_tracker.sv]
// ----------------------------------------------------------------------------
// windowed_mean_min_max_tracker
// Per-channel moving average with running minimum and maximum.
// Path: front register, command queue, pipeline stages a to d, result queue.
// Throughput: one item per cycle unless a queue fills; the channel state is
//   updated as its item is popped. Reset: rings and sums zero, trackers and
//   bounds at their start values, both queues empty; no clearing pass.
// ----------------------------------------------------------------------------
module windowed_mean_min_max_tracker
  import wmt_pkg::*;
#(
  parameter int unsigned CHANNELS    = 4,
  parameter int unsigned WINDOW      = 5,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic signed [CFG_BITS-1:0]    cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic                          operation_i,
  input  logic [CH_BITS-1:0]            channel_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [CH_BITS-1:0]            channel_out_o,
  output logic signed [SAMPLE_BITS-1:0] window_mean_o,
  output logic signed [SAMPLE_BITS-1:0] running_min_o,
  output logic signed [SAMPLE_BITS-1:0] running_max_o
);

  localparam int unsigned MIDW = $bits(ctrl_t) + SAMPLE_BITS;
  localparam int unsigned OUTW = CH_BITS + 3 * SAMPLE_BITS;

  logic                          mid_push, mid_pop, mid_full, mid_empty;
  ctrl_t                         mid_ctrl_w, mid_ctrl_r;
  logic signed [SAMPLE_BITS-1:0] mid_sample_w, mid_sample_r;
  logic [MIDW-1:0]               mid_rdata;

  logic                          res_push;
  logic [CH_BITS-1:0]            res_channel;
  logic signed [SAMPLE_BITS-1:0] res_mean, res_min, res_max;
  logic [OUTW-1:0]               out_rdata;
  logic [$clog2(OUT_DEPTH):0]    out_count;

  wmt_front #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .operation_i (operation_i),
    .channel_i   (channel_i),
    .sample_i    (sample_i),
    .q_push_o    (mid_push),
    .q_ctrl_o    (mid_ctrl_w),
    .q_sample_o  (mid_sample_w),
    .q_full_i    (mid_full)
  );

  wmt_fifo #(
    .WIDTH (MIDW),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  ({mid_ctrl_w, mid_sample_w}),
    .pop_i   (mid_pop),
    .data_o  (mid_rdata),
    .full_o  (mid_full),
    .empty_o (mid_empty),
    .count_o ()
  );

  assign mid_ctrl_r   = mid_rdata[MIDW-1:SAMPLE_BITS];
  assign mid_sample_r = mid_rdata[SAMPLE_BITS-1:0];

  wmt_back #(
    .CHANNELS    (CHANNELS),
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .q_empty_i     (mid_empty),
    .q_ctrl_i      (mid_ctrl_r),
    .q_sample_i    (mid_sample_r),
    .q_pop_o       (mid_pop),
    .out_count_i   (out_count),
    .res_push_o    (res_push),
    .res_channel_o (res_channel),
    .res_mean_o    (res_mean),
    .res_min_o     (res_min),
    .res_max_o     (res_max)
  );

  wmt_fifo #(
    .WIDTH (OUTW),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  ({res_channel, res_mean, res_min, res_max}),
    .pop_i   (pop),
    .data_o  (out_rdata),
    .full_o  (),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign channel_out_o = out_rdata[OUTW-1 -: CH_BITS];
  assign window_mean_o = out_rdata[3*SAMPLE_BITS-1 -: SAMPLE_BITS];
  assign running_min_o = out_rdata[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
  assign running_max_o = out_rdata[SAMPLE_BITS-1:0];

endmodule

[src/wmt_checker.sv]
// ----------------------------------------------------------------------------
// wmt_checker
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module wmt_checker
  import wmt_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          push,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic [CH_BITS-1:0]            channel_out_o,
  input logic signed [SAMPLE_BITS-1:0] window_mean_o,
  input logic signed [SAMPLE_BITS-1:0] running_min_o,
  input logic signed [SAMPLE_BITS-1:0] running_max_o
);

  // items taken but not yet delivered
  logic [4:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = push & ~full;
  assign out_acc = pop & ~empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  // the queue flags read idle on the edge after reset is seen
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> empty && !full)
    else $error("queue flags not idle in reset");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(channel_out_o) && $stable(window_mean_o)
      && $stable(running_min_o) && $stable(running_max_o))
    else $error("waiting result changed");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> pend_q != '0)
    else $error("result without a pending item");

  a_idle_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == '0 |-> !full)
    else $error("full with nothing pending");

endmodule

bind windowed_mean_min_max_tracker wmt_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_wmt_checker (.*);
